// ===== sv/sof_length_frame_deframer_assert.svh =====
// assertion macros shared by the deframer modules
// expects clk and rst_n in the scope of each use
`ifndef SOF_LENGTH_FRAME_DEFRAMER_ASSERT_SVH
`define SOF_LENGTH_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SLFD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slfd assertion failed");

// next-cycle implication, checked outside reset
`define SLFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slfd assertion failed");

`endif

// ===== sv/slfd_pkg.sv =====
// types and constants for the sof/length frame deframer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package slfd_pkg;

  // input item command codes
  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // result kinds
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // start-of-frame pair
  localparam logic [7:0] SOF_FIRST  = 8'h11;
  localparam logic [7:0] SOF_SECOND = 8'hEF;

  // header bytes rescanned after a bad length (bytes 2..7)
  localparam logic [2:0] REPLAY_BYTES = 3'd6;

  // depth of the queue between front and back
  localparam int QDEPTH = 2;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [8:0]  data_index;
    logic [15:0] resp_command;
    logic [7:0]  resp_status;
    logic [9:0]  data_length;
    logic        last;
  } out_item_t;

  typedef enum logic {
    ITEM_BYTE,
    ITEM_CLEAR
  } q_kind_t;

  // classified item as it sits in the queue
  typedef struct packed {
    q_kind_t    kind;
    logic [7:0] rx_byte;
  } q_item_t;

endpackage

`default_nettype wire

// ===== sv/slfd_front.sv =====
// front end: accepts items, classifies them and queues them for the parser
// depends on slfd_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "sof_length_frame_deframer_assert.svh"

module slfd_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  slfd_pkg::in_item_t  in_item,
  output logic                q_valid,
  output slfd_pkg::q_item_t   q_item,
  input  wire                 q_pop
);
  import slfd_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  q_item_t            q_mem_r [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               push;
  q_item_t            push_item;

  assign in_stall = (cnt_r == CNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = q_mem_r[rd_ptr_r];

  always_comb begin
    push_item.kind    = (in_item.command == CMD_CLEAR) ? ITEM_CLEAR : ITEM_BYTE;
    push_item.rx_byte = in_item.rx_byte;
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_item;
    end
  end

  `SLFD_ASSERT_IMPL(a_pop_needs_item, q_pop, q_valid)
  `SLFD_ASSERT_NEXT(a_fill_grows, push && !q_pop, cnt_r == $past(cnt_r) + 1'b1)
  `SLFD_ASSERT_NEXT(a_drain_shrinks, q_pop && !push, cnt_r == $past(cnt_r) - 1'b1)

endmodule

`default_nettype wire

// ===== sv/slfd_back.sv =====
// back end: frame parser with header replay and the result register
// depends on slfd_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "sof_length_frame_deframer_assert.svh"

module slfd_back #(
  parameter int MAX_DATA = 512
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 q_valid,
  input  slfd_pkg::q_item_t   q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  wire                 out_stall,
  output slfd_pkg::out_item_t out_item
);
  import slfd_pkg::*;

  localparam int LEN_W = $clog2(MAX_DATA + 1);
  localparam int SR_W  = 8 * int'(REPLAY_BYTES);

  // header byte positions
  localparam logic [2:0] HP_CMD_HI = 3'd2;
  localparam logic [2:0] HP_CMD_LO = 3'd3;
  localparam logic [2:0] HP_SKIP   = 3'd4;
  localparam logic [2:0] HP_STATUS = 3'd5;
  localparam logic [2:0] HP_LEN_HI = 3'd6;
  localparam logic [2:0] HP_LEN_LO = 3'd7;

  typedef enum logic [2:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_HEADER,
    PH_HCSUM,
    PH_BODY
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [2:0]       hpos_r, hpos_nxt;
  logic [15:0]      cmd_r, cmd_nxt;
  logic [7:0]       skip_r, skip_nxt;
  logic [7:0]       status_r, status_nxt;
  logic [7:0]       len_hi_r, len_hi_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic [2:0]       replay_cnt_r, replay_cnt_nxt;
  logic [SR_W-1:0]  replay_sr_r, replay_sr_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  logic        go;
  logic        replaying;
  logic        step;
  logic        is_clear;
  logic [7:0]  b;
  logic [15:0] len_full;

  assign go        = !out_valid_r || !out_stall;
  assign replaying = (replay_cnt_r != '0);
  assign q_pop     = q_valid && go && !replaying;
  assign step      = q_pop || replaying;
  assign is_clear  = !replaying && (q_item.kind == ITEM_CLEAR);
  assign b         = replaying ? replay_sr_r[SR_W-1 -: 8] : q_item.rx_byte;
  assign len_full  = {len_hi_r, b};

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    phase_nxt      = phase_r;
    hpos_nxt       = hpos_r;
    cmd_nxt        = cmd_r;
    skip_nxt       = skip_r;
    status_nxt     = status_r;
    len_hi_nxt     = len_hi_r;
    len_nxt        = len_r;
    idx_nxt        = idx_r;
    replay_cnt_nxt = replay_cnt_r;
    replay_sr_nxt  = replay_sr_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_item_nxt   = out_item_r;

    if (replaying) begin
      replay_cnt_nxt = replay_cnt_r - 1'b1;
      replay_sr_nxt  = {replay_sr_r[SR_W-9:0], 8'h00};
    end

    if (step) begin
      if (is_clear) begin
        phase_nxt = PH_HUNT1;
      end else begin
        case (phase_r)
          PH_HUNT1: begin
            if (b == SOF_FIRST) begin
              phase_nxt = PH_HUNT2;
            end
          end
          PH_HUNT2: begin
            if (b == SOF_SECOND) begin
              phase_nxt = PH_HEADER;
              hpos_nxt  = HP_CMD_HI;
            end else if (b != SOF_FIRST) begin
              phase_nxt = PH_HUNT1;
            end
          end
          PH_HEADER: begin
            hpos_nxt = hpos_r + 1'b1;
            case (hpos_r)
              HP_CMD_HI: cmd_nxt[15:8] = b;
              HP_CMD_LO: cmd_nxt[7:0]  = b;
              HP_SKIP:   skip_nxt      = b;
              HP_STATUS: status_nxt    = b;
              HP_LEN_HI: len_hi_nxt    = b;
              HP_LEN_LO: begin
                if (len_full > 16'(MAX_DATA)) begin
                  // bad length: drop the start pair, rescan bytes 2..7
                  phase_nxt      = PH_HUNT1;
                  replay_cnt_nxt = REPLAY_BYTES;
                  replay_sr_nxt  = {cmd_r, skip_r, status_r, len_hi_r, b};
                end else begin
                  len_nxt   = LEN_W'(len_full);
                  phase_nxt = PH_HCSUM;
                end
              end
              default: ;
            endcase
          end
          PH_HCSUM: begin
            phase_nxt = PH_BODY;
            idx_nxt   = '0;
          end
          PH_BODY: begin
            out_valid_nxt             = 1'b1;
            out_item_nxt.resp_command = cmd_r;
            out_item_nxt.resp_status  = status_r;
            out_item_nxt.data_length  = 10'(len_r);
            if (idx_r < len_r) begin
              out_item_nxt.kind       = KIND_DATA;
              out_item_nxt.data_byte  = b;
              out_item_nxt.data_index = 9'(idx_r);
              out_item_nxt.last       = 1'b0;
              idx_nxt                 = idx_r + 1'b1;
            end else begin
              out_item_nxt.kind       = KIND_SUMMARY;
              out_item_nxt.data_byte  = 8'h00;
              out_item_nxt.data_index = 9'd0;
              out_item_nxt.last       = 1'b1;
              phase_nxt               = PH_HUNT1;
            end
          end
          default: phase_nxt = PH_HUNT1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT1;
      replay_cnt_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      replay_cnt_r <= replay_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    hpos_r      <= hpos_nxt;
    cmd_r       <= cmd_nxt;
    skip_r      <= skip_nxt;
    status_r    <= status_nxt;
    len_hi_r    <= len_hi_nxt;
    len_r       <= len_nxt;
    idx_r       <= idx_nxt;
    replay_sr_r <= replay_sr_nxt;
    out_item_r  <= out_item_nxt;
  end

  `SLFD_ASSERT_NEXT(a_replay_counts_down, replay_cnt_r != '0,
                    replay_cnt_r == $past(replay_cnt_r) - 1'b1)
  `SLFD_ASSERT_NEXT(a_replay_no_result, replay_cnt_r != '0,
                    out_valid_r == ($past(out_valid_r) && $past(out_stall)))
  `SLFD_ASSERT_IMPL(a_replay_from_header, $rose(replay_cnt_r != '0),
                    $past(phase_r) == PH_HEADER)
  `SLFD_ASSERT_IMPL(a_index_in_range, phase_r == PH_BODY, idx_r <= len_r)

endmodule

`default_nettype wire

// ===== sv/sof_length_frame_deframer.sv =====
// top level of the sof/length frame deframer: front queue plus parser back end
// depends on slfd_pkg, slfd_front and slfd_back
`timescale 1ns / 1ps
`default_nettype none

// channel   dir   handshake           payload
// in_       in    in_valid/in_stall   slfd_pkg::in_item_t  (command, rx_byte)
// out_      out   out_valid/out_stall slfd_pkg::out_item_t (kind .. last)
//
// one item per cycle through the parser while the result register drains and no
//   header replay runs; a length above MAX_DATA makes the same parser rescan the
//   header bytes 2..7 one per cycle, and the queue stalls meanwhile
// a two-entry queue parts the front from the parser, so in_stall rises only when full
// results sit in one output register, held steady while out_stall is high
// reset (rst_n low, synchronous) empties the queue and restarts the start-pair hunt

module sof_length_frame_deframer #(
  parameter int MAX_DATA = 512
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  slfd_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  wire                 out_stall,
  output slfd_pkg::out_item_t out_item
);
  import slfd_pkg::*;

  // queue between front and back
  logic    q_valid;
  logic    q_pop;
  q_item_t q_item;

  // front: accepts and classifies items
  slfd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // back: frame parser, header replay and result register
  slfd_back #(
    .MAX_DATA (MAX_DATA)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
